// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Command codes on the request channel
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Character codes with special meaning
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] TAB_CODE     = 8'd9;

  // Tab stop distance and attribute after reset
  localparam int unsigned TAB_STEP    = 4;
  localparam logic [7:0]  RESET_COLOR = 8'h07;

  // Decoded operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_DRAW    = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_TAB     = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_NOP     = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  ch;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        last;
  } op_t;

endpackage

// ===== src/text_console_writer_unit.sv =====
// Top level of the text console writer.
//
// Requests arrive on s_axis: tuser carries the command (put byte, read cell,
// clear screen), tdata the character and the cell position to read, tlast the
// end of a write burst (no effect on the screen). Each request gives exactly
// one result on m_axis: the cell read (0 for other commands) and the cursor
// position after the request. The color register is written via cfg_we.
// A decoder feeds a two-entry queue; the engine behind it owns the screen RAM.
// Printable bytes, newlines, tabs, bad reads and unused commands finish in the
// idle state; a cell read passes through the read state (registered RAM read);
// a clear and any request that scrolls sweep every cell once through the single
// RAM write port.
// After reset the engine writes every cell to a space with color 0x07;
// s_axis_tready stays low until that pass is done.
// When m_axis is stalled one result waits in the output register, the queue
// keeps taking requests until it holds two, then s_axis_tready drops.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13], zero
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // cell_value[15:0], cursor_row[20:16], cursor_col[27:21], zero
);
  import tcw_pkg::*;

  op_t         op_head;
  logic        op_valid;
  logic        op_pop;
  logic        init_busy;
  logic [15:0] res_value;
  logic [4:0]  res_row;
  logic [6:0]  res_col;

  // Decode requests and queue them
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_char   (s_axis_tdata[7:0]),
    .in_row    (s_axis_tdata[12:8]),
    .in_col    (s_axis_tdata[19:13]),
    .in_last   (s_axis_tlast),
    .init_busy (init_busy),
    .op_valid  (op_valid),
    .op_head   (op_head),
    .op_pop    (op_pop)
  );

  // Execute operations against the screen
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op_valid  (op_valid),
    .op_head   (op_head),
    .op_pop    (op_pop),
    .init_busy (init_busy),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_value (res_value),
    .res_row   (res_row),
    .res_col   (res_col)
  );

  // Pack the result
  assign m_axis_tdata = {4'b0000, res_col, res_row, res_value};

endmodule

// ===== src/tcw_front.sv =====
// Request decoder and two-entry operation queue.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_cmd,
  input  logic [7:0]    in_char,
  input  logic [4:0]    in_row,
  input  logic [6:0]    in_col,
  input  logic          in_last,
  input  logic          init_busy,
  output logic          op_valid,
  output tcw_pkg::op_t  op_head,
  input  logic          op_pop
);
  import tcw_pkg::*;

  localparam logic [6:0] ROWS_LIM = 7'(ROWS);
  localparam logic [7:0] COLS_LIM = 8'(COLUMNS);

  op_t        decoded;
  op_t        q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       read_in_range;

  // Classify the request
  assign read_in_range = ({2'b00, in_row} < ROWS_LIM) && ({1'b0, in_col} < COLS_LIM);

  always_comb begin
    decoded.ch   = in_char;
    decoded.row  = in_row;
    decoded.col  = in_col;
    decoded.last = in_last;
    unique case (in_cmd)
      CMD_PUT: begin
        if (in_char == NEWLINE_CODE) begin
          decoded.kind = OP_NEWLINE;
        end else if (in_char == TAB_CODE) begin
          decoded.kind = OP_TAB;
        end else begin
          decoded.kind = OP_DRAW;
        end
      end
      CMD_READ:  decoded.kind = read_in_range ? OP_READ : OP_NOP;
      CMD_CLEAR: decoded.kind = OP_CLEAR;
      default:   decoded.kind = OP_NOP;
    endcase
  end

  // Hold off requests while full or while the screen is being initialized
  assign in_ready = (count != 2'd2) && !init_busy;
  assign push     = in_valid && in_ready;
  assign op_valid = (count != 2'd0);
  assign op_head  = q_mem[rd_ptr];

  // Store decoded operations
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= decoded;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (op_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, op_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/tcw_back.sv =====
// Execution engine: screen memory, cursor, scroll and clear sweeps, result register.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          op_valid,
  input  tcw_pkg::op_t  op_head,
  output logic          op_pop,
  output logic          init_busy,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [15:0]   res_value,
  output logic [4:0]    res_row,
  output logic [6:0]    res_col
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SHIFT_END = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]    COL_LIM   = (COL_W + 1)'(COLUMNS);
  localparam logic [COL_W:0]    TAB_INC   = (COL_W + 1)'(TAB_STEP);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FILL   = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  idx, idx_next;
  logic [ROW_W-1:0]   cur_row, cur_row_next;
  logic [COL_W-1:0]   cur_col, cur_col_next;
  logic [7:0]         text_color;

  logic [15:0]        screen [CELLS];
  logic [15:0]        mem_rdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [15:0]        mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  op_addr;
  logic [COL_W:0]     col_inc;
  logic [COL_W:0]     col_tab;
  logic [COL_W:0]     col_tab_wrap;
  logic [ROW_W+4:0]   row_wide;
  logic [COL_W+6:0]   col_wide;
  logic               slot_free;
  logic               produce;
  logic               adv_row;
  logic [15:0]        value_next;

  assign cur_addr     = ADDR_W'(cur_row * COLUMNS + cur_col);
  assign op_addr      = ADDR_W'(op_head.row * COLUMNS + op_head.col);
  assign col_inc      = {1'b0, cur_col} + (COL_W + 1)'(1);
  assign col_tab      = {1'b0, cur_col} + TAB_INC;
  assign col_tab_wrap = col_tab - COL_LIM;
  assign slot_free    = !res_valid || res_ready;
  assign init_busy    = (state == ST_INIT);

  // Sequence the current operation
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = {text_color, SPACE_CODE};
    mem_raddr    = idx + ROW_STEP;
    op_pop       = 1'b0;
    produce      = 1'b0;
    adv_row      = 1'b0;
    value_next   = 16'h0000;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_COLOR, SPACE_CODE};
        if (idx == LAST_CELL) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (op_valid && slot_free) begin
          op_pop = 1'b1;
          case (op_head.kind)
            OP_DRAW: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {text_color, op_head.ch};
              produce   = 1'b1;
              if (col_inc >= COL_LIM) begin
                cur_col_next = '0;
                adv_row      = 1'b1;
              end else begin
                cur_col_next = col_inc[COL_W-1:0];
              end
            end
            OP_NEWLINE: begin
              cur_col_next = '0;
              adv_row      = 1'b1;
              produce      = 1'b1;
            end
            OP_TAB: begin
              produce = 1'b1;
              if (col_tab >= COL_LIM) begin
                cur_col_next = col_tab_wrap[COL_W-1:0];
                adv_row      = 1'b1;
              end else begin
                cur_col_next = col_tab[COL_W-1:0];
              end
            end
            OP_READ: begin
              mem_raddr  = op_addr;
              state_next = ST_READ;
            end
            OP_CLEAR: begin
              idx_next   = '0;
              state_next = ST_FILL;
            end
            default: produce = 1'b1;
          endcase
          // Move down a row, or scroll when already on the bottom row
          if (adv_row) begin
            if (cur_row == ROW_LAST) begin
              produce    = 1'b0;
              idx_next   = '0;
              state_next = ST_SCROLL;
            end else begin
              cur_row_next = cur_row + ROW_W'(1);
            end
          end
        end
      end
      ST_READ: begin
        produce    = 1'b1;
        value_next = mem_rdata;
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read one row below, write back the cell read last cycle
        if (idx != '0) begin
          mem_we    = 1'b1;
          mem_waddr = idx - ADDR_W'(1);
          mem_wdata = mem_rdata;
        end
        if (idx == SHIFT_END) begin
          state_next = ST_FILL;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (idx == LAST_CELL) begin
          produce    = 1'b1;
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Screen memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= screen[mem_raddr];
  end

  // Control state, cursor and color
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      idx        <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      text_color <= RESET_COLOR;
      res_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      if (produce) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Fit cursor to the result field widths
  assign row_wide = {5'b00000, cur_row_next};
  assign col_wide = {7'b0000000, cur_col_next};

  // Load the result register
  always_ff @(posedge clk) begin
    if (produce) begin
      res_value <= value_next;
      res_row   <= row_wide[4:0];
      res_col   <= col_wide[6:0];
    end
  end

endmodule

// ===== tb/sv/tb_text_console_writer_unit.sv =====
// Testbench for the text console writer: streamed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT = 8;
  localparam int HOLD_CYCLES = 3000;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 270;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] rrow;
    logic [6:0] rcol;
    logic       last;
  } console_req_t;

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'h0;  // char_code[7:0], read_row[12:8], read_col[19:13], zero
  logic [1:0]  s_axis_tuser = 2'b00;  // cmd[1:0]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // cell_value[15:0], cursor_row[20:16], cursor_col[27:21], zero

  // Predicted console state
  logic [15:0]  screen_mem [CELLS];
  int unsigned  cur_row;
  int unsigned  cur_col;
  logic [7:0]   text_color_m;

  console_req_t req_pending_q [$];
  console_rsp_t rsp_expect_q [$];
  console_req_t cur_req;

  int  errors = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;
  bit  stall_arm = 1'b0;
  bit  stall_done = 1'b0;

  text_console_writer_unit #(
    .COLUMNS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Move the cursor down one row, scrolling the screen at the bottom
  function automatic void cursor_next_row();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int y = 1; y < ROWS; y++) begin
        for (int x = 0; x < COLS; x++) begin
          screen_mem[(y - 1) * COLS + x] = screen_mem[y * COLS + x];
        end
      end
      for (int x = 0; x < COLS; x++) begin
        screen_mem[(ROWS - 1) * COLS + x] = {text_color_m, SPACE_CODE};
      end
      cur_row = ROWS - 1;
    end
  endfunction

  // Apply one request to the predicted screen and return the expected result
  function automatic console_rsp_t console_apply(console_req_t r);
    console_rsp_t rsp;
    rsp.value = 16'h0;
    case (r.cmd)
      CMD_PUT: begin
        if (r.ch == NEWLINE_CODE) begin
          cur_col = 0;
          cursor_next_row();
        end else if (r.ch == TAB_CODE) begin
          cur_col += TAB_STEP;
          if (cur_col >= COLS) begin
            cur_col -= COLS;
            cursor_next_row();
          end
        end else begin
          screen_mem[cur_row * COLS + cur_col] = {text_color_m, r.ch};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cursor_next_row();
          end
        end
      end
      CMD_READ: begin
        if (r.rrow < ROWS && r.rcol < COLS) rsp.value = screen_mem[r.rrow * COLS + r.rcol];
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = {text_color_m, SPACE_CODE};
      end
      default: ;
    endcase
    rsp.row = cur_row[4:0];
    rsp.col = cur_col[6:0];
    return rsp;
  endfunction

  function automatic void queue_req(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rrow,
                                    logic [6:0] rcol, logic last);
    console_req_t r;
    r.cmd = cmd;
    r.ch = ch;
    r.rrow = rrow;
    r.rcol = rcol;
    r.last = last;
    req_pending_q.push_back(r);
  endfunction

  // Random traffic: write bursts, tab runs, cell reads, clears and unused commands
  task automatic gen_traffic(int target);
    int count;
    int roll;
    int len;
    logic [7:0] ch;
    count = 0;
    while (count < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) ch = NEWLINE_CODE;
          else if (roll < 14) ch = TAB_CODE;
          else ch = 8'($urandom_range(0, 255));
          queue_req(CMD_PUT, ch, 5'($urandom), 7'($urandom), i == len - 1);
        end
        count += len;
      end else if (roll < 80) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 85)
            queue_req(CMD_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                      7'($urandom_range(0, COLS - 1)), 1'($urandom));
          else
            queue_req(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom), 1'($urandom));
        end
        count += len;
      end else if (roll < 86) begin
        queue_req(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom), 1'($urandom));
        count++;
      end else if (roll < 90) begin
        // no effect on the screen, not counted
        queue_req(CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom), 1'($urandom));
      end else begin
        len = $urandom_range(1, 25);
        for (int i = 0; i < len; i++) queue_req(CMD_PUT, TAB_CODE, 5'($urandom), 7'($urandom), 1'b0);
        count += len;
      end
    end
  endtask

  // Hold until every request is sent and every result is back
  task automatic wait_drain();
    while (req_pending_q.size() != 0 || s_axis_tvalid || rsp_expect_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_color(logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_color_m = value;
  endtask

  // Request driver
  always @(posedge clk) begin
    bit load;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      load = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        rsp_expect_q.push_back(console_apply(cur_req));
        load = 1'b1;
      end
      if (load) begin
        if (req_pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = req_pending_q.pop_front();
          s_axis_tdata <= {4'h0, cur_req.rcol, cur_req.rrow, cur_req.ch};
          s_axis_tuser <= cur_req.cmd;
          s_axis_tlast <= cur_req.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk) begin
    console_rsp_t got;
    console_rsp_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[15:0];
        got.row = m_axis_tdata[20:16];
        got.col = m_axis_tdata[27:21];
        if (rsp_expect_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = rsp_expect_q.pop_front();
          if (got.value !== want.value) begin
            errors++;
            $display("%0t cell_value: expected %h, actual %h", $time, want.value, got.value);
          end
          if (got.row !== want.row) begin
            errors++;
            $display("%0t cursor_row: expected %0d, actual %0d", $time, want.row, got.row);
          end
          if (got.col !== want.col) begin
            errors++;
            $display("%0t cursor_col: expected %0d, actual %0d", $time, want.col, got.col);
          end
        end
      end
      // one long hold-off so the request side backs up
      if (stall_arm && !stall_done) begin
        hold_left = HOLD_CYCLES;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_mem[i] = {RESET_COLOR, SPACE_CODE};
    cur_row = 0;
    cur_col = 0;
    text_color_m = RESET_COLOR;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // hold off until the power-up clearing pass is done
    while (!s_axis_tready) @(posedge clk);

    // Directed: byte extremes, every command, reads at the corners and out of range
    write_color(8'h4F);
    queue_req(CMD_READ, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_req(CMD_READ, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1), 1'b1);
    queue_req(CMD_PUT, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_req(CMD_PUT, 8'hFF, 5'h1F, 7'h7F, 1'b0);
    queue_req(CMD_PUT, NEWLINE_CODE, 5'd0, 7'd0, 1'b0);
    queue_req(CMD_PUT, TAB_CODE, 5'd0, 7'd0, 1'b0);
    queue_req(CMD_PUT, 8'h41, 5'd0, 7'd0, 1'b1);
    queue_req(CMD_READ, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_req(CMD_READ, 8'h00, 5'd0, 7'd1, 1'b0);
    queue_req(CMD_READ, 8'h00, 5'd1, 7'd4, 1'b0);
    queue_req(CMD_READ, 8'h00, 5'h1F, 7'd0, 1'b0);
    queue_req(CMD_READ, 8'h00, 5'd0, 7'h7F, 1'b0);
    queue_req(CMD_READ, 8'h00, 5'(ROWS), 7'(COLS), 1'b0);
    queue_req(CMD_UNUSED, 8'hFF, 5'h1F, 7'h7F, 1'b1);
    queue_req(CMD_CLEAR, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_req(CMD_READ, 8'h00, 5'd0, 7'd0, 1'b0);
    wait_drain();

    // Random phases across colors; one without idling, one with a long receiver hold
    write_color(8'h00);
    gen_traffic(PHASE_ITEMS);
    wait_drain();

    write_color(8'hFF);
    steady = 1'b1;
    gen_traffic(PHASE_ITEMS);
    wait_drain();
    steady = 1'b0;

    write_color(8'($urandom_range(0, 255)));
    stall_arm = 1'b1;
    gen_traffic(PHASE_ITEMS);
    wait_drain();

    write_color(8'($urandom_range(0, 255)));
    gen_traffic(PHASE_ITEMS);
    wait_drain();

    write_color(RESET_COLOR);
    gen_traffic(PHASE_ITEMS);
    wait_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
